// ----- rtl/binary_to_decimal_ascii_assert.svh -----
// ============================================================================
// binary_to_decimal_ascii assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ============================================================================
`ifndef BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// expr holds at every edge outside reset
`define B2DA_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// whenever ante holds, cons holds at the same edge
`define B2DA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/b2da_pkg.sv -----
// ============================================================================
// b2da_pkg
// Shared constants and helpers for the binary to decimal ASCII converter.
// ============================================================================
`default_nettype none

package b2da_pkg;

    localparam int VALUE_BITS        = 64;
    localparam int VALUE_WIDTH_DEF   = 64;
    localparam int CHAR_BITS         = 8;
    localparam int RADIX             = 10;
    localparam int FIFO_DEPTH        = 2;

    localparam logic KIND_SIGNED     = 1'b0;
    localparam logic KIND_UNSIGNED   = 1'b1;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_NINE  = 8'd57;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

    // Decimal digits needed for the largest w-bit unsigned number.
    function automatic int dec_digits(input int w);
        longint unsigned m;
        int              n;
        m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        n = 0;
        for (int i = 0; i < 20; i++)
        begin
            if (m != 0)
            begin
                n++;
                m = m / 64'(RADIX);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/b2da_in_if.sv -----
// ============================================================================
// b2da_in_if
// Input channel: a word and its signed/unsigned kind flag.
// ============================================================================
`default_nettype none

interface b2da_in_if
    import b2da_pkg::*;
();

    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

`default_nettype wire

// ----- rtl/b2da_out_if.sv -----
// ============================================================================
// b2da_out_if
// Output channel: one ASCII character per word, with an end-of-number flag.
// ============================================================================
`default_nettype none

interface b2da_out_if
    import b2da_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] character;
    logic                 last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);

endinterface

`default_nettype wire

// ----- rtl/binary_to_decimal_ascii.sv -----
// ============================================================================
// binary_to_decimal_ascii
// Binary word to decimal ASCII text converter.
// item: valid/ready channel carrying kind (0 signed, 1 unsigned) and a 64-bit
//   value; only the low VALUE_WIDTH bits are used, the top one as sign when
//   signed. A word is accepted when valid and ready are high at a clock edge.
// text: valid/ready channel giving the decimal characters most significant
//   first, with a leading '-' for a negative signed value and last on the
//   final digit. Zero gives the single character '0'.
// A word passes the queue, the converter and the emitter; a leading '-' for
//   a negative value comes first, then leading zeros are skipped (up to
//   NDIG - 1), then one digit per cycle unless stalled.
// The bit-serial double dabble unit converts one word at a time, shifting
//   one bit a cycle; it takes no new word until its result is taken.
//   Emitting a number (up to 20 characters plus zero skipping) overlaps with
//   the next conversion, and a two-word queue buffers input ahead of it.
// A stalled text channel holds its character; the converter keeps working
//   and input stops only when the queue is full.
// Reset clears the queue, the converter and the output; no clearing pass.
// ============================================================================
`default_nettype none

module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    b2da_in_if.sink    item,
    b2da_out_if.source text
);

    localparam int NDIG   = dec_digits(VALUE_WIDTH);
    localparam int WORK_W = VALUE_WIDTH + 1;

    logic                   push_valid;
    logic                   push_ready;
    logic                   push_neg;
    logic [VALUE_WIDTH-1:0] push_mag;
    logic                   pop_valid;
    logic                   pop_ready;
    logic [WORK_W-1:0]      pop_data;
    logic                   res_valid;
    logic                   res_ready;
    logic                   res_neg;
    logic [4*NDIG-1:0]      res_bcd;

    b2da_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_neg   (push_neg),
        .push_mag   (push_mag)
    );

    b2da_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_neg, push_mag}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    b2da_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (pop_valid),
        .src_ready (pop_ready),
        .src_neg   (pop_data[WORK_W-1]),
        .src_mag   (pop_data[VALUE_WIDTH-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_neg   (res_neg),
        .res_bcd   (res_bcd)
    );

    b2da_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_neg   (res_neg),
        .res_bcd   (res_bcd),
        .text      (text)
    );

endmodule

`default_nettype wire

// ----- rtl/b2da_front.sv -----
// ============================================================================
// b2da_front
// Accepts input words, decides the sign and forms the unsigned magnitude.
// ============================================================================
`default_nettype none

module b2da_front
    import b2da_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    b2da_in_if.sink               item,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic                  push_neg,
    output logic [VALUE_WIDTH-1:0] push_mag
);

    logic [VALUE_WIDTH-1:0] word;

    assign word       = item.value[VALUE_WIDTH-1:0];
    assign push_neg   = (item.kind == KIND_SIGNED) && word[VALUE_WIDTH-1];
    // two's complement negate; the most negative value maps to itself, which
    // read unsigned is the right magnitude
    assign push_mag   = push_neg ? VALUE_WIDTH'(~word + VALUE_WIDTH'(1)) : word;
    assign push_valid = item.valid;
    assign item.ready = push_ready;

endmodule

`default_nettype wire

// ----- rtl/b2da_fifo.sv -----
// ============================================================================
// b2da_fifo
// Small queue between the front end and the converter.
// ============================================================================
`default_nettype none

module b2da_fifo
    import b2da_pkg::*;
#(
    parameter int WIDTH = VALUE_WIDTH_DEF + 1,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    `include "binary_to_decimal_ascii_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `B2DA_ASSERT_ALWAYS(a_fifo_count_bound, count_reg <= CNT_W'(DEPTH),
        "fifo count above depth")

endmodule

`default_nettype wire

// ----- rtl/b2da_dabble.sv -----
// ============================================================================
// b2da_dabble
// Bit-serial double dabble: one magnitude bit shifted into BCD per cycle.
// ============================================================================
`default_nettype none

module b2da_dabble
    import b2da_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int NDIG        = dec_digits(VALUE_WIDTH_DEF)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   src_valid,
    output logic                   src_ready,
    input  logic                   src_neg,
    input  logic [VALUE_WIDTH-1:0] src_mag,
    output logic                   res_valid,
    input  logic                   res_ready,
    output logic                   res_neg,
    output logic [4*NDIG-1:0]      res_bcd
);

    `include "binary_to_decimal_ascii_assert.svh"

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   busy_reg, busy_next;
    logic                   res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [4*NDIG-1:0]      bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;
    logic [4*NDIG-1:0]      bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    assign src_ready = !busy_reg && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_neg   = neg_reg;
    assign res_bcd   = bcd_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (src_valid && src_ready)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = CNT_W'(VALUE_WIDTH - 1);
            shift_next   = src_mag;
            bcd_next     = '0;
            neg_next     = src_neg;
        end
        else if (busy_reg)
        begin
            bcd_next   = {bcd_adj[4*NDIG-2:0], shift_reg[VALUE_WIDTH-1]};
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            if (bit_cnt_reg == '0)
            begin
                busy_next      = 1'b0;
                res_valid_next = 1'b1;
            end
            else
            begin
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
    end

    `B2DA_ASSERT_ALWAYS(a_dabble_busy_no_result, !(busy_reg && res_valid_reg),
        "converter busy while a result is pending")
    `B2DA_ASSERT_IMPL(a_dabble_done_after_last_bit, $rose(res_valid_reg),
        $past(busy_reg) && ($past(bit_cnt_reg) == '0),
        "result raised before all bits were shifted")

endmodule

`default_nettype wire

// ----- rtl/b2da_emit.sv -----
// ============================================================================
// b2da_emit
// Turns one BCD result into characters: sign, zero skip, then digits.
// ============================================================================
`default_nettype none

module b2da_emit
    import b2da_pkg::*;
#(
    parameter int NDIG = dec_digits(VALUE_WIDTH_DEF)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  logic              res_neg,
    input  logic [4*NDIG-1:0] res_bcd,
    b2da_out_if.source        text
);

    `include "binary_to_decimal_ascii_assert.svh"

    localparam int LEFT_W = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_SKIP,
        ST_DIGIT
    } state_t;

    state_t               state_reg, state_next;
    logic [4*NDIG-1:0]    digits_reg, digits_next;
    logic [LEFT_W-1:0]    left_reg, left_next;
    logic                 ov_reg, ov_next;
    logic [CHAR_BITS-1:0] char_reg, char_next;
    logic                 last_reg, last_next;
    logic [3:0]           top_digit;
    logic                 out_free;

    assign top_digit      = digits_reg[4*NDIG-1 -: 4];
    assign out_free       = !ov_reg || text.ready;
    assign res_ready      = (state_reg == ST_IDLE);
    assign text.valid     = ov_reg;
    assign text.character = char_reg;
    assign text.last      = last_reg;

    always_comb
    begin
        state_next  = state_reg;
        digits_next = digits_reg;
        left_next   = left_reg;
        ov_next     = ov_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        if (text.ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (res_valid)
                begin
                    digits_next = res_bcd;
                    left_next   = LEFT_W'(NDIG);
                    state_next  = res_neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    char_next  = ASCII_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keep the units digit
                if (top_digit == 4'd0 && left_reg != LEFT_W'(1))
                begin
                    digits_next = {digits_reg[4*NDIG-5:0], 4'd0};
                    left_next   = left_reg - LEFT_W'(1);
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    char_next   = ASCII_ZERO + {4'd0, top_digit};
                    last_next   = (left_reg == LEFT_W'(1));
                    digits_next = {digits_reg[4*NDIG-5:0], 4'd0};
                    left_next   = left_reg - LEFT_W'(1);
                    if (left_reg == LEFT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        left_reg   <= left_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    `B2DA_ASSERT_IMPL(a_emit_char_legal, ov_reg,
        (char_reg == ASCII_MINUS) || ((char_reg >= ASCII_ZERO) && (char_reg <= ASCII_NINE)),
        "output character is neither sign nor digit")
    `B2DA_ASSERT_IMPL(a_emit_sign_not_last, ov_reg && (char_reg == ASCII_MINUS), !last_reg,
        "sign flagged as final character")

endmodule

`default_nettype wire

// ----- bench/b2da_text_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// b2da_text_checker
// Watches the word and text channels of the converter. Every accepted word
// is turned into its expected decimal characters, and every accepted
// character is compared with the oldest one still due.
// ============================================================================

module b2da_text_checker
    import b2da_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    b2da_in_if    item,
    b2da_out_if   text,
    output int    mismatches,
    output int    chars_due
);

    localparam logic [VALUE_BITS-1:0] WORD_MASK =
        {VALUE_BITS{1'b1}} >> (VALUE_BITS - VALUE_WIDTH);

    typedef struct packed {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } text_char_t;

    text_char_t expected_text [$];

    initial
    begin
        mismatches = 0;
        chars_due  = 0;
    end

    // Decimal text of one word, most significant character first.
    function automatic void queue_decimal_text(input logic kind,
                                               input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] word;
        logic [VALUE_BITS-1:0] mag;
        logic [3:0]            digits [0:23];
        logic                  negative;
        int                    n;
        int                    k;
        word     = value & WORD_MASK;
        negative = (kind == KIND_SIGNED) && word[VALUE_WIDTH-1];
        // unsigned negation keeps the most negative value exact
        mag      = negative ? ((~word + 1'b1) & WORD_MASK) : word;
        n        = 0;
        do
        begin
            digits[n] = 4'(mag % RADIX);
            mag       = mag / RADIX;
            n++;
        end
        while (mag != 0);
        if (negative)
            expected_text.push_back('{character: ASCII_MINUS, last: 1'b0});
        for (k = n - 1; k >= 0; k--)
            expected_text.push_back('{character: ASCII_ZERO + CHAR_BITS'(digits[k]),
                                      last: (k == 0)});
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (text.valid && text.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("character: expected none, actual %0d (last %0b)",
                           text.character, text.last);
                    mismatches++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (text.character !== want.character)
                    begin
                        $error("character: expected %0d, actual %0d",
                               want.character, text.character);
                        mismatches++;
                    end
                    if (text.last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, text.last);
                        mismatches++;
                    end
                end
            end
            if (item.valid && item.ready)
                queue_decimal_text(item.kind, item.value);
            chars_due = expected_text.size();
        end
    end

endmodule

// ----- bench/tb_binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_binary_to_decimal_ascii
// Drives signed and unsigned words into the converter: a directed set of
// extremes and edge values, then random words with random gaps on the input
// and random stalls on the text side, including one long stall that backs
// the block up. The checker compares every character and flag.
// ============================================================================

module tb_binary_to_decimal_ascii;
    import b2da_pkg::*;

    localparam int  WIDTH        = VALUE_WIDTH_DEF;
    localparam int  PERIOD       = 20;
    localparam int  RANDOM_WORDS = 360;
    localparam int  HOLD_AFTER   = 140;
    localparam int  HOLD_CYCLES  = 800;
    localparam int  DRAIN_CYCLES = 100;

    localparam logic [VALUE_BITS-1:0] ALL_ONES  = {VALUE_BITS{1'b1}};
    localparam logic [VALUE_BITS-1:0] MOST_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_BITS-1:0] MOST_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

    logic clk   = 1'b0;
    logic rst_n;
    logic hold_text = 1'b0;
    int   words_sent = 0;
    int   stall_left = 0;
    bit   text_calm  = 1'b0;
    bit   item_calm  = 1'b0;
    int   mismatches;
    int   chars_due;

    b2da_in_if  item_bus ();
    b2da_out_if text_bus ();

    binary_to_decimal_ascii #(.VALUE_WIDTH(WIDTH)) u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_bus),
        .text  (text_bus)
    );

    b2da_text_checker #(.VALUE_WIDTH(WIDTH)) u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_bus),
        .text       (text_bus),
        .mismatches (mismatches),
        .chars_due  (chars_due)
    );

    always #(PERIOD / 2) clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [VALUE_BITS-1:0] power_of_ten(input int k);
        logic [VALUE_BITS-1:0] p;
        int                    i;
        p = 1;
        for (i = 0; i < k; i++)
            p = p * RADIX;
        return p;
    endfunction

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] full;
        int                    r;
        full = {$urandom, $urandom};
        r    = $urandom_range(0, 9);
        if (r < 3)
            return full;
        else if (r < 5)
            return full >> $urandom_range(0, 63);
        else if (r == 5)
            return ~(full >> $urandom_range(1, 63));
        else if (r < 8)
        begin
            full = power_of_ten($urandom_range(0, 19)) + $urandom_range(0, 2) - 1;
            return $urandom_range(0, 1) ? full : -full;
        end
        else if (r == 8)
            return (64'd1 << $urandom_range(0, 63)) - $urandom_range(0, 1);
        else
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return ALL_ONES;
                2: return MOST_NEG;
                default: return MOST_POS;
            endcase
        end
    endfunction

    // called at a rising edge; returns at the edge that accepts the word
    task automatic send_word(input logic kind, input logic [VALUE_BITS-1:0] value);
        int gap;
        gap = 0;
        if (!item_calm && $urandom_range(0, 2) == 0)
            gap = idle_cycles();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.kind  <= kind;
        item_bus.value <= value;
        do
            @(posedge clk);
        while (!item_bus.ready);
        words_sent++;
        if ($urandom_range(0, 39) == 0)
            item_calm = !item_calm;
    endtask

    // text side: random stalls, calm stretches, and the long hold
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!text_calm && $urandom_range(0, 3) == 0)
            stall_left = idle_cycles();
        if ($urandom_range(0, 299) == 0)
            text_calm = !text_calm;
        text_bus.ready <= rst_n && !hold_text && (stall_left == 0);
    end

    initial
    begin
        wait (words_sent == HOLD_AFTER);
        @(posedge clk);
        hold_text <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_text <= 1'b0;
    end

    initial
    begin
        #(3_000_000 * PERIOD);
        $display("tb_binary_to_decimal_ascii: errors");
        $finish;
    end

    initial
    begin
        int i;
        rst_n          <= 1'b0;
        item_bus.valid <= 1'b0;
        item_bus.kind  <= KIND_SIGNED;
        item_bus.value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_word(KIND_UNSIGNED, '0);
        send_word(KIND_SIGNED,   '0);
        send_word(KIND_UNSIGNED, ALL_ONES);
        send_word(KIND_SIGNED,   ALL_ONES);
        send_word(KIND_SIGNED,   MOST_NEG);
        send_word(KIND_UNSIGNED, MOST_NEG);
        send_word(KIND_SIGNED,   MOST_POS);
        send_word(KIND_UNSIGNED, MOST_POS);
        send_word(KIND_UNSIGNED, 64'd1);
        send_word(KIND_SIGNED,   64'd9);
        send_word(KIND_UNSIGNED, 64'd10);
        send_word(KIND_SIGNED,   64'd99);
        send_word(KIND_UNSIGNED, 64'd100);
        send_word(KIND_SIGNED,   -64'd9);
        send_word(KIND_SIGNED,   -64'd10);
        send_word(KIND_UNSIGNED, 64'd10000000000000000000);
        send_word(KIND_UNSIGNED, 64'd9999999999999999999);
        send_word(KIND_SIGNED,   64'd1000000000000000000);
        send_word(KIND_SIGNED,   MOST_NEG + 64'd1);
        send_word(KIND_UNSIGNED, 64'hA5A5_5A5A_F0F0_0F0F);

        for (i = 0; i < RANDOM_WORDS; i++)
            send_word(logic'($urandom_range(0, 1)), random_value());
        item_bus.valid <= 1'b0;

        // let the checker count the last word before waiting on the drain
        @(posedge clk);
        wait (chars_due == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && chars_due == 0)
            $display("tb_binary_to_decimal_ascii: clean");
        else
            $display("tb_binary_to_decimal_ascii: errors");
        $finish;
    end

endmodule
